@@ src/tcpop_pkg.sv @@
// Shared constants and types for the TCP option parser.
package tcpop_pkg;
  localparam int MaxOptionBytes = 40;
  localparam logic [15:0] InitMssReset = 16'd1460;
  localparam logic [31:0] InitWindowReset = 32'd8760;
  localparam logic [0:0] RegInitMss = 1'b0;
  localparam logic [0:0] RegInitWindow = 1'b1;
  localparam logic KindStart = 1'b0;
  localparam logic KindByte = 1'b1;
  localparam logic ResSack = 1'b0;
  localparam logic ResSummary = 1'b1;
  localparam logic [7:0] OptEnd = 8'd0;
  localparam logic [7:0] OptNop = 8'd1;
  localparam logic [7:0] OptMss = 8'd2;
  localparam logic [7:0] OptWscale = 8'd3;
  localparam logic [7:0] OptSack = 8'd5;

  typedef struct packed {
    logic       kind;
    logic [3:0] data_offset;
    logic       syn_flag;
    logic [5:0] option_bytes_available;
    logic [7:0] option_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] sack_left_edge;
    logic [31:0] sack_right_edge;
    logic [15:0] mss_now;
    logic [31:0] rx_window_now;
    logic [7:0]  peer_scale_factor;
    logic        scaling_enabled;
    logic        mss_was_lowered;
    logic        parse_stopped_early;
    logic        last_of_run;
  } out_item_t;

  // Front-to-back command: at most one SACK block and one summary per byte.
  typedef struct packed {
    logic        sack;
    logic [31:0] left;
    logic [31:0] right;
    logic        mss_upd;
    logic [15:0] mss_val;
    logic        wsc_upd;
    logic [7:0]  wsc_val;
    logic        summary;
    logic        stopped;
  } cmd_t;
endpackage

@@ src/tcpop_if.sv @@
// Valid/ready channel interfaces for input and result words.
interface tcpop_in_if;
  import tcpop_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tcpop_out_if;
  import tcpop_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/tcp_option_parser_top.sv @@
// Top level of the TCP option parser.
// Channels: in (start and option-byte words), out (SACK block and summary words),
// plus a write-only register port (index 0 initial MSS, 1 initial window).
// A start word either opens an option area or, if it is absent or does not fit,
// yields a summary at once. Option bytes follow one per word; the last byte of
// the area yields the summary. A completed SACK block yields a SACK word.
// Throughput: one word per cycle while no result is pending; a word that yields
// results is taken, then the back end emits its results one at a time. An MSS that
// lowers the kept MSS first runs a bit-serial divide and then a multiply step.
// The back end's single output register holds a result while out.ready is low;
// the front stops accepting while the back end is busy.
// Reset (rst, synchronous) loads the kept MSS and window from their defaults
// and clears all walk state. Register writes also reload the kept values.
module tcp_option_parser_top import tcpop_pkg::*; #(
  parameter int MAX_OPTION_BYTES = MaxOptionBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  tcpop_in_if.sink    in,
  tcpop_out_if.source out
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  tcpop_front #(.MAX_OPTION_BYTES(MAX_OPTION_BYTES)) u_front (
    .clk, .rst, .in_valid(in.valid), .in_ready(in.ready), .in_data(in.data),
    .syn_ok(1'b1), .cmd_valid, .cmd_ready, .cmd
  );

  tcpop_back u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cmd_valid, .cmd_ready, .cmd,
    .out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
  );
endmodule

@@ src/tcpop_front.sv @@
// Option walker: consumes words and issues commands to the back end.
module tcpop_front import tcpop_pkg::*; #(
  parameter int MAX_OPTION_BYTES = MaxOptionBytes
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     syn_ok,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);
  typedef enum logic [1:0] {PH_IDLE, PH_CODE, PH_LEN, PH_BODY} phase_t;
  phase_t phase;
  logic [5:0] bytes_left;
  logic [7:0] code, len, pos;
  logic [63:0] shift;
  logic syn_latched, stopped;
  logic [6:0] area;
  logic [7:0] b, d, full;
  logic [6:0] rem_start;
  logic [15:0] mss16;
  logic fire;
  cmd_t c;

  assign in_ready = cmd_ready;
  assign fire = in_valid & in_ready;
  assign b = in_data.option_byte;
  assign area = {1'b0, in_data.data_offset - 4'd5, 2'b00};
  assign rem_start = {1'b0, bytes_left} + 7'd1;
  assign d = pos - 8'd2;
  assign full = (len - 8'd2) & 8'hF8;
  assign mss16 = {shift[7:0], b};

  always_comb begin
    c = '0;
    c.stopped = stopped;
    cmd_valid = 1'b0;
    if (fire) begin
      if (in_data.kind == KindStart) begin
        if (!(in_data.data_offset > 4'd5 && area <= {1'b0, in_data.option_bytes_available}
              && area <= 7'(MAX_OPTION_BYTES))) begin
          c.summary = 1'b1;
          c.stopped = 1'b0;
          cmd_valid = 1'b1;
        end
      end else if (phase != PH_IDLE && bytes_left != 6'd0) begin
        if (!stopped && phase == PH_CODE && b == OptEnd) c.stopped = 1'b1;
        if (!stopped && phase == PH_CODE && b != OptNop && bytes_left < 6'd2)
          c.stopped = 1'b1;
        if (!stopped && phase == PH_LEN) begin
          if (code == OptWscale && (rem_start < 7'd3 || b != 8'd3)) c.stopped = 1'b1;
          else if (code == OptMss && (rem_start < 7'd4 || b != 8'd4)) c.stopped = 1'b1;
          else if (code != OptWscale && code != OptMss &&
                   (b < 8'd2 || {1'b0, rem_start} < b)) c.stopped = 1'b1;
        end
        if (!stopped && phase == PH_BODY) begin
          if (code == OptMss && pos == 8'd3 && syn_ok && mss16 == 16'd0) c.stopped = 1'b1;
          if (code == OptWscale && syn_latched) begin
            c.wsc_upd = 1'b1;
            c.wsc_val = b;
          end else if (code == OptMss && pos == 8'd3) begin
            c.mss_upd = 1'b1;
            c.mss_val = mss16;
          end else if (code == OptSack && d < full && d[2:0] == 3'd7) begin
            c.sack = 1'b1;
            c.left = shift[55:24];
            c.right = {shift[23:0], b};
          end
        end
        c.summary = (bytes_left == 6'd1);
        cmd_valid = c.sack | c.mss_upd | c.wsc_upd | c.summary;
      end
    end
  end
  assign cmd = c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bytes_left <= '0;
      code <= '0;
      len <= '0;
      pos <= '0;
      shift <= '0;
      syn_latched <= 1'b0;
      stopped <= 1'b0;
    end else if (fire) begin
      if (in_data.kind == KindStart) begin
        syn_latched <= in_data.syn_flag;
        stopped <= 1'b0;
        code <= '0;
        len <= '0;
        pos <= '0;
        shift <= '0;
        phase <= PH_IDLE;
        bytes_left <= '0;
        if (in_data.data_offset > 4'd5 && area <= {1'b0, in_data.option_bytes_available}
            && area <= 7'(MAX_OPTION_BYTES)) begin
          bytes_left <= area[5:0];
          phase <= PH_CODE;
        end
      end else if (phase == PH_IDLE || bytes_left == 6'd0) begin
        phase <= PH_IDLE;
      end else begin
        if (!stopped) begin
          case (phase)
            PH_CODE: begin
              code <= b;
              if (b == OptEnd) stopped <= 1'b1;
              else if (b == OptNop) ;
              else if (bytes_left < 6'd2) stopped <= 1'b1;
              else begin
                phase <= PH_LEN;
                pos <= 8'd1;
              end
            end
            PH_LEN: begin
              len <= b;
              pos <= 8'd2;
              shift <= '0;
              if (c.stopped) stopped <= 1'b1;
              else if (code != OptWscale && code != OptMss && b == 8'd2) phase <= PH_CODE;
              else phase <= PH_BODY;
            end
            PH_BODY: begin
              pos <= pos + 8'd1;
              if (code == OptWscale) phase <= PH_CODE;
              else if (code == OptMss) begin
                shift <= {48'd0, mss16};
                if (pos == 8'd3) begin
                  if (syn_ok && mss16 == 16'd0) stopped <= 1'b1;
                  else phase <= PH_CODE;
                end
              end else begin
                if (code == OptSack && d < full) begin
                  shift <= (d[2:0] == 3'd7) ? 64'd0 : {shift[55:0], b};
                end
                if (pos + 8'd1 >= len) phase <= PH_CODE;
              end
            end
            default: ;
          endcase
        end
        bytes_left <= bytes_left - 6'd1;
        if (bytes_left == 6'd1) phase <= PH_IDLE;
      end
    end
  end
endmodule

@@ src/tcpop_back.sv @@
// Kept-state engine: applies commands, runs the window divide, emits words.
module tcpop_back import tcpop_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_SACK, S_SUM} state_t;
  state_t state;
  cmd_t cur;
  logic [15:0] kmss;
  logic [31:0] kwin;
  logic [7:0] scale;
  logic scale_on, lowered;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [5:0] cnt;
  logic [16:0] trial;
  logic [31:0] prod;
  logic hold;

  assign hold = out_valid && !out_ready;
  assign cmd_ready = (state == S_IDLE) && !hold;
  assign trial = {rem[15:0], quo[31]};
  assign prod = 32'(quo * {16'd0, cur.mss_val});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      kmss <= InitMssReset;
      kwin <= InitWindowReset;
      scale <= '0;
      scale_on <= 1'b0;
      lowered <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == RegInitMss) kmss <= cfg_data[15:0];
        else kwin <= cfg_data;
      end
      case (state)
        S_IDLE: if (cmd_valid && cmd_ready) begin
          cur <= cmd;
          if (cmd.wsc_upd) begin
            scale <= cmd.wsc_val;
            scale_on <= 1'b1;
          end
          if (cmd.mss_upd && cmd.mss_val != 16'd0 && kmss > cmd.mss_val) begin
            quo <= kwin;
            rem <= '0;
            cnt <= 6'd32;
            state <= S_DIV;
          end else if (cmd.sack) state <= S_SACK;
          else if (cmd.summary) state <= S_SUM;
        end
        S_DIV: begin
          // one quotient bit per cycle
          if (trial >= {1'b0, cur.mss_val}) begin
            rem <= trial - {1'b0, cur.mss_val};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= trial;
            quo <= {quo[30:0], 1'b0};
          end
          cnt <= cnt - 6'd1;
          if (cnt == 6'd1) state <= S_MUL;
        end
        S_MUL: begin
          kwin <= prod;
          kmss <= cur.mss_val;
          lowered <= 1'b1;
          state <= cur.summary ? S_SUM : S_IDLE;
        end
        S_SACK: if (!hold) begin
          out_valid <= 1'b1;
          out_data <= '{ResSack, cur.left, cur.right, kmss, kwin, scale, scale_on,
                        lowered, 1'b0, !cur.summary};
          state <= cur.summary ? S_SUM : S_IDLE;
        end
        S_SUM: if (!(out_valid && !out_ready) && !(state == S_SUM && out_valid && cur.sack
                 && !out_ready)) begin
          out_valid <= 1'b1;
          out_data <= '{ResSummary, 32'd0, 32'd0, kmss, kwin, scale, scale_on,
                        lowered, cur.stopped, 1'b1};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_mss_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cur.mss_val != 16'd0)) else $error("divide by zero mss");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == 6'd1) |=> (state == S_MUL)) else $error("divide length");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif
endmodule
